>>> hw/rtl/njs_pkg.sv
// shared types and constants for the job scheduler
package njs_pkg;

    localparam int ENTRY_W = 44;

    localparam logic [1:0] MODE_FCFS = 2'd0;
    localparam logic [1:0] MODE_SJF  = 2'd1;
    localparam logic [1:0] MODE_PRIO = 2'd2;

    localparam logic OP_SUBMIT   = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_ZERO_RUN = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [7:0]  job_id;
        logic [15:0] submit_tenths;
        logic [15:0] run_tenths;
        logic [3:0]  job_priority;
    } njs_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  out_job_id;
        logic [15:0] start_tenths;
        logic [15:0] wait_tenths;
        logic [15:0] finish_tenths;
        logic [15:0] turnaround_tenths;
        logic [15:0] weighted_turnaround;
        logic [4:0]  ready_count;
    } njs_out_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] submit;
        logic [15:0] run;
        logic [3:0]  prio;
    } njs_entry_t;

endpackage

>>> hw/rtl/nonpreemptive_job_scheduler.sv
// non-preemptive job scheduler: ordered ready store in ram, dispatch timing
//
//  channel  | ports                     | payload
//  ---------+---------------------------+-----------------------
//  input    | s_valid / s_ready / s_data | njs_in_t (submit/dispatch)
//  result   | m_valid / m_ready / m_data | njs_out_t
//  config   | cfg_valid / cfg_ready / cfg_data | order_mode
//
// a submit walks the store from the tail, a read and a compare/write state per
// entry looked at, one more write when the job lands at the head.
// a dispatch takes the head entry out and moves every other entry down one
// place (a read and a write state each), then loads and runs a 24-step
// restoring divider.
// reset clears fill count and processor time and sets order mode to sjf; ram contents stay.
// the result sits in an output register; a new transaction is taken only
// once it has been delivered.
module nonpreemptive_job_scheduler #(
    parameter int READY_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  njs_pkg::njs_in_t     s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output njs_pkg::njs_out_t    m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_data
);
    import njs_pkg::*;

    localparam int AW = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
    localparam int CW = $clog2(READY_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRD   = 3'd1; // submit: read entry
    localparam logic [2:0] S_SCHK  = 3'd2; // submit: compare/move
    localparam logic [2:0] S_DRD   = 3'd3; // dispatch: read entry
    localparam logic [2:0] S_DMOV  = 3'd4; // dispatch: write down
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] S_SINS  = 3'd7; // submit: write at the head

    logic [2:0]       state_reg, state_next;
    logic [1:0]       mode_reg;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [15:0]      ptime_reg, ptime_next;
    logic [CW-1:0]    idx_reg, idx_next;
    njs_entry_t       fresh_reg, fresh_next;
    njs_entry_t       head_reg, head_next;
    njs_out_t         res_reg, res_next;
    logic             mval_reg, mval_next;
    logic [23:0]      quo_reg, quo_next;
    logic [16:0]      rem_reg, rem_next;
    logic [4:0]       dcnt_reg, dcnt_next;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    njs_entry_t       wdata, rdata;
    logic [ENTRY_W-1:0] rraw;

    njs_ram #(.WIDTH(ENTRY_W), .DEPTH(READY_DEPTH)) u_store (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rraw)
    );
    assign rdata = njs_entry_t'(rraw);

    assign s_ready   = (state_reg == S_IDLE) && !mval_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = mval_reg;
    assign m_data    = res_reg;

    // held entry stays ahead of the fresh one
    logic held_first;
    always_comb begin
        unique case (mode_reg)
            MODE_SJF:  held_first = rdata.run <= fresh_reg.run;
            MODE_PRIO: held_first = rdata.prio <= fresh_reg.prio;
            default:   held_first = 1'b1;
        endcase
    end

    // timing of the head job
    logic [15:0] start_t, finish_t;
    logic [16:0] fsum;
    assign start_t  = (ptime_reg > head_reg.submit) ? ptime_reg : head_reg.submit;
    assign fsum     = {1'b0, start_t} + {1'b0, head_reg.run};
    assign finish_t = fsum[16] ? 16'hFFFF : fsum[15:0];

    // divider step
    logic [17:0] trial;
    assign trial = {rem_reg, quo_reg[23]} - {2'b0, head_reg.run};

    // control and datapath
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        ptime_next = ptime_reg;
        idx_next   = idx_reg;
        fresh_next = fresh_reg;
        head_next  = head_reg;
        res_next   = res_reg;
        mval_next  = mval_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        we         = 1'b0;
        waddr      = idx_reg[AW-1:0];
        wdata      = fresh_reg;
        raddr      = idx_reg[AW-1:0];
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    res_next = '0;
                    fresh_next.id     = s_data.job_id;
                    fresh_next.submit = s_data.submit_tenths;
                    fresh_next.run    = s_data.run_tenths;
                    fresh_next.prio   = s_data.job_priority;
                    if (s_data.operation == OP_SUBMIT) begin
                        if (fill_reg >= CW'(READY_DEPTH)) begin
                            res_next.status      = ST_FULL;
                            res_next.ready_count = 5'(fill_reg);
                            state_next           = S_OUT;
                        end else if (fill_reg == '0) begin
                            // empty store: write at the head
                            we          = 1'b1;
                            waddr       = '0;
                            wdata       = fresh_next;
                            fill_next   = fill_reg + 1'b1;
                            res_next.ready_count = 5'(fill_reg + 1'b1);
                            state_next  = S_OUT;
                        end else begin
                            // walk from the tail down
                            idx_next   = fill_reg - 1'b1;
                            state_next = S_SRD;
                        end
                    end else begin
                        if (fill_reg == '0) begin
                            res_next.status = ST_EMPTY;
                            state_next      = S_OUT;
                        end else begin
                            idx_next   = '0;
                            state_next = S_DRD;
                        end
                    end
                end
            end
            S_SRD: begin
                raddr      = idx_reg[AW-1:0];
                state_next = S_SCHK;
            end
            S_SCHK: begin
                we = 1'b1;
                if (held_first) begin
                    // fresh goes just after this entry
                    waddr = AW'(idx_reg + 1'b1);
                    wdata = fresh_reg;
                    fill_next  = fill_reg + 1'b1;
                    res_next.ready_count = 5'(fill_reg + 1'b1);
                    state_next = S_OUT;
                end else begin
                    waddr = AW'(idx_reg + 1'b1);
                    wdata = rdata;
                    if (idx_reg == '0) begin
                        state_next = S_SINS;
                        idx_next   = '0;
                    end else begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = S_SRD;
                    end
                end
            end
            S_SINS: begin
                // fresh job lands at the head
                we         = 1'b1;
                waddr      = '0;
                wdata      = fresh_reg;
                fill_next  = fill_reg + 1'b1;
                res_next.ready_count = 5'(fill_reg + 1'b1);
                state_next = S_OUT;
            end
            S_DRD: begin
                raddr      = idx_reg[AW-1:0];
                state_next = S_DMOV;
            end
            S_DMOV: begin
                if (idx_reg == '0) begin
                    head_next = rdata;
                end else begin
                    we    = 1'b1;
                    waddr = AW'(idx_reg - 1'b1);
                    wdata = rdata;
                end
                if (idx_reg + 1'b1 >= fill_reg) begin
                    fill_next  = fill_reg - 1'b1;
                    state_next = S_DIV;
                    dcnt_next  = '0;
                    rem_next   = '0;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_DRD;
                end
            end
            S_DIV: begin
                if (dcnt_reg == 5'd0) begin
                    // load turnaround * 256 as dividend
                    quo_next  = {finish_t - head_reg.submit, 8'd0};
                    rem_next  = '0;
                    dcnt_next = 5'd1;
                end else if (dcnt_reg <= 5'd24) begin
                    if (!trial[17]) begin
                        rem_next = trial[16:0];
                        quo_next = {quo_reg[22:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[15:0], quo_reg[23]};
                        quo_next = {quo_reg[22:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg + 1'b1;
                end else begin
                    res_next.out_job_id        = head_reg.id;
                    res_next.start_tenths      = start_t;
                    res_next.wait_tenths       = start_t - head_reg.submit;
                    res_next.finish_tenths     = finish_t;
                    res_next.turnaround_tenths = finish_t - head_reg.submit;
                    res_next.ready_count       = 5'(fill_reg);
                    ptime_next                 = finish_t;
                    if (head_reg.run == '0) begin
                        res_next.status              = ST_ZERO_RUN;
                        res_next.weighted_turnaround = '0;
                    end else begin
                        res_next.status = ST_OK;
                        res_next.weighted_turnaround =
                            (quo_reg[23:16] != '0) ? 16'hFFFF : quo_reg[15:0];
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                mval_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mode_reg  <= MODE_SJF;
            fill_reg  <= '0;
            ptime_reg <= '0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            ptime_reg <= ptime_next;
            mval_reg  <= mval_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
        idx_reg   <= idx_next;
        fresh_reg <= fresh_next;
        head_reg  <= head_next;
        res_reg   <= res_next;
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
    end

    // checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CW'(READY_DEPTH)) else $error("fill above depth");
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("input taken while busy");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result dropped");
endmodule

>>> hw/rtl/njs_ram.sv
// generic single-port-write, single-port-read ram with registered read
module njs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> verif/nonpreemptive_job_scheduler_checker.sv
// checker for the job scheduler: tracks config and input transactions, predicts results
`timescale 1ns / 1ps

module nonpreemptive_job_scheduler_checker #(
    parameter int READY_DEPTH = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  njs_pkg::njs_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  njs_pkg::njs_out_t m_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [1:0]        cfg_data,
    output int                fail_count,
    output int                pending_results
);
    import njs_pkg::*;

    // scheduler shadow state
    logic [1:0]  sched_mode;
    njs_entry_t  job_queue[$];
    logic [15:0] cpu_free_tenths;
    njs_out_t    expected_results[$];

    assign pending_results = expected_results.size();

    // true when the queued job stays ahead of the new one
    function automatic bit stays_ahead(njs_entry_t held, njs_entry_t fresh);
        if (sched_mode == MODE_SJF) return held.run <= fresh.run;
        if (sched_mode == MODE_PRIO) return held.prio <= fresh.prio;
        return 1'b1;
    endfunction

    // work out the result of one transaction and update the shadow state
    function automatic njs_out_t schedule_job(njs_in_t item);
        njs_out_t   res;
        njs_entry_t fresh;
        njs_entry_t head;
        int         pos;
        int unsigned start_t;
        int unsigned finish_t;
        int unsigned turn_t;
        int unsigned wait_t;
        longint unsigned ratio;
        res = '0;
        if (item.operation == OP_SUBMIT) begin
            fresh.id = item.job_id;
            fresh.submit = item.submit_tenths;
            fresh.run = item.run_tenths;
            fresh.prio = item.job_priority;
            if (job_queue.size() >= READY_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < job_queue.size() && stays_ahead(job_queue[pos], fresh)) pos++;
                job_queue.insert(pos, fresh);
                res.status = ST_OK;
            end
        end else if (job_queue.size() == 0) begin
            res.status = ST_EMPTY;
        end else begin
            head = job_queue.pop_front();
            start_t = (cpu_free_tenths > head.submit) ? cpu_free_tenths : head.submit;
            finish_t = start_t + head.run;
            if (finish_t > 32'hFFFF) finish_t = 32'hFFFF;
            turn_t = finish_t - head.submit;
            wait_t = start_t - head.submit;
            cpu_free_tenths = finish_t[15:0];
            res.out_job_id = head.id;
            res.start_tenths = start_t[15:0];
            res.wait_tenths = wait_t[15:0];
            res.finish_tenths = finish_t[15:0];
            res.turnaround_tenths = turn_t[15:0];
            if (head.run == 0) begin
                res.status = ST_ZERO_RUN;
            end else begin
                ratio = (longint'(turn_t) << 8) / head.run;
                res.status = ST_OK;
                res.weighted_turnaround = (ratio > 64'hFFFF) ? 16'hFFFF : ratio[15:0];
            end
        end
        res.ready_count = 5'(job_queue.size());
        return res;
    endfunction

    // watch the channels at each rising edge
    always @(posedge aclk) begin
        njs_out_t want;
        if (!aresetn) begin
            sched_mode <= MODE_SJF;
            cpu_free_tenths = '0;
            job_queue.delete();
            expected_results.delete();
            fail_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready) sched_mode <= cfg_data;
            if (s_valid && s_ready) expected_results.push_back(schedule_job(s_data));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result transaction %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want !== m_data) begin
                        if (fail_count < 10)
                            $display("result mismatch: expected %p, got %p", want, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> verif/nonpreemptive_job_scheduler_test.sv
// testbench top for the job scheduler: stimulus, idling and verdict
`timescale 1ns / 1ps

module nonpreemptive_job_scheduler_test;
    import njs_pkg::*;

    localparam int DEPTH = 16;
    localparam int STALL_LIMIT = 20000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    njs_in_t    s_data;
    logic       m_valid;
    logic       m_ready;
    njs_out_t   m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    int         fail_count;
    int         pending_results;
    int         quiet_cycles = 0;

    nonpreemptive_job_scheduler #(.READY_DEPTH(DEPTH)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    nonpreemptive_job_scheduler_checker #(.READY_DEPTH(DEPTH)) i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side back-pressure, short and long stretches
    initial begin
        int stall_phase;
        m_ready = 1'b0;
        stall_phase = 0;
        forever begin
            @(negedge aclk);
            if (stall_phase > 0) begin
                stall_phase--;
                m_ready <= 1'b0;
            end else begin
                stall_phase = gap_length();
                if (stall_phase > 0) begin
                    stall_phase--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // send one transaction after a random gap
    task automatic send_item(input njs_in_t item, input bit idle_first);
        int gap;
        gap = idle_first ? gap_length() : 0;
        repeat (gap + 1) @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic submit_job(input logic [7:0] id, input logic [15:0] sub,
                              input logic [15:0] run, input logic [3:0] prio);
        njs_in_t item;
        item.operation = OP_SUBMIT;
        item.job_id = id;
        item.submit_tenths = sub;
        item.run_tenths = run;
        item.job_priority = prio;
        send_item(item, 1'b1);
    endtask

    // dispatch carries random content in the ignored fields
    task automatic dispatch_job();
        njs_in_t item;
        item = njs_in_t'($bits(njs_in_t)'({$urandom, $urandom}));
        item.operation = OP_DISPATCH;
        send_item(item, 1'b1);
    endtask

    // write order mode once all results are back
    task automatic write_mode(input logic [1:0] mode);
        while (pending_results != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random job with mostly small times and some extremes
    task automatic random_submit();
        logic [15:0] sub;
        logic [15:0] run;
        sub = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
        case ($urandom_range(0, 9))
            0: run = 16'd0;
            1: run = 16'($urandom);
            2: run = 16'hFFFF;
            default: run = 16'($urandom_range(1, 600));
        endcase
        submit_job(8'($urandom), sub, run, 4'($urandom));
    endtask

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("** nonpreemptive_job_scheduler: FAILED **");
            $finish;
        end
    end

    initial begin
        int count;
        int burst;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = MODE_SJF;
        aresetn = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: empty dispatch, extremes, zero run, saturation, fill to full
        dispatch_job();
        submit_job(8'hFF, 16'hFFFF, 16'hFFFF, 4'hF);
        submit_job(8'h00, 16'h0000, 16'h0000, 4'h0);
        submit_job(8'h5A, 16'd10, 16'd1, 4'h7);
        dispatch_job();
        dispatch_job();
        dispatch_job();
        dispatch_job();
        for (int i = 0; i < DEPTH + 1; i++) submit_job(8'(i), 16'(i * 3), 16'(20 - i), 4'(i));
        for (int i = 0; i < DEPTH + 1; i++) dispatch_job();

        // random phases across all order modes, including the unused one
        count = 0;
        for (int phase = 0; phase < 8; phase++) begin
            write_mode(phase == 7 ? MODE_SJF : 2'(phase % 4));
            while (count < (phase + 1) * 130) begin
                burst = $urandom_range(1, DEPTH + 2);
                for (int i = 0; i < burst; i++) begin
                    if ($urandom_range(0, 9) < 8) random_submit();
                    else dispatch_job();
                end
                for (int i = 0; i < burst; i++) dispatch_job();
                count += 2 * burst;
            end
        end

        while (pending_results != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0)
            $display("** nonpreemptive_job_scheduler: PASSED **");
        else
            $display("** nonpreemptive_job_scheduler: FAILED **");
        $finish;
    end

endmodule
